@@ sv/keypad_scan_debounce_core_defines.svh @@
// shared assertion macros
`ifndef KEYPAD_SCAN_DEBOUNCE_CORE_DEFINES_SVH
`define KEYPAD_SCAN_DEBOUNCE_CORE_DEFINES_SVH

// same-cycle implication
`define KPSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KPSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/kpsd_pkg.sv @@
package kpsd_pkg;

   localparam int unsigned RowWidth      = 4;
   localparam int unsigned KeyWidth      = 16;
   localparam int unsigned DriveWidth    = 8;
   localparam int unsigned CountWidth    = 8;
   localparam int unsigned IdleWidth     = 16;
   localparam int unsigned ColIdxWidth   = 2;
   localparam int unsigned ReqDataWidth  = 24;
   localparam int unsigned RspDataWidth  = 32;

   localparam logic [CountWidth-1:0]  PressReset   = 8'd20;
   localparam logic [CountWidth-1:0]  PressRestart = 8'd10;
   localparam logic [CountWidth-1:0]  PressCapture = 8'd9;
   localparam logic [CountWidth-1:0]  ReleaseLoad  = 8'd20;
   localparam logic [DriveWidth-1:0]  FirstColBit  = 8'h80;
   localparam logic [IdleWidth-1:0]   LockDelayReset = 16'd500;
   localparam logic [ColIdxWidth-1:0] LastCol      = 2'd3;

   typedef enum logic {
      MODE_SCAN = 1'b0,
      MODE_READ = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [RowWidth-1:0]   row_sample;
      logic [KeyWidth-1:0]   key_mask;
   } req_item_type;

   typedef struct packed {
      logic [DriveWidth-1:0] column_drive;
      logic [KeyWidth-1:0]   key_bits;
      logic                  lock_flag;
      logic                  read_ready;
   } rsp_item_type;

   function automatic logic [DriveWidth-1:0] col_drive(input logic [ColIdxWidth-1:0] idx);
      col_drive = ~(FirstColBit >> idx);
   endfunction

endpackage

@@ sv/keypad_scan_debounce_core.sv @@
// channel   direction  fields, lowest bit first
// req       in         tdata: row_sample[3:0] key_mask[19:4]; tuser: mode
// rsp       out        tdata: column_drive[7:0] key_bits[23:8] lock_flag[24] read_ready[25]
// csr       in         wdata: lock_delay
//
// one transaction per cycle unless rsp stalls; req reaches rsp through the input and output registers
// the debounce state loop closes through the combinational scan core update
// synchronous active-high reset; state is ready the cycle after reset drops
// a stalled rsp holds its register and stops req only once the input register is full
module keypad_scan_debounce_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [kpsd_pkg::ReqDataWidth-1:0]     req_tdata,  // row_sample, key_mask
   input  logic                                  req_tuser,  // mode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [kpsd_pkg::RspDataWidth-1:0]     rsp_tdata,  // column_drive, key_bits, lock_flag, read_ready
   input  logic                                  csr_we,
   input  logic [kpsd_pkg::IdleWidth-1:0]        csr_wdata
);
   import kpsd_pkg::*;

   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         out_ready;
   logic         fire;

   assign fire = item_valid && out_ready;

   kpsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   kpsd_scan_core u_scan_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (item),
      .result    (result)
   );

   kpsd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ sv/kpsd_in_reg.sv @@
module kpsd_in_reg (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [kpsd_pkg::ReqDataWidth-1:0]     req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  take,
   output logic                                  item_valid,
   output kpsd_pkg::req_item_type                item
);
   import kpsd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;

   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_comb begin
      item_in.mode       = mode_type'(req_tuser);
      item_in.row_sample = req_tdata[RowWidth-1:0];
      item_in.key_mask   = req_tdata[RowWidth+KeyWidth-1:RowWidth];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ sv/kpsd_scan_core.sv @@
`include "keypad_scan_debounce_core_defines.svh"

module kpsd_scan_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [kpsd_pkg::IdleWidth-1:0]     csr_wdata,
   input  logic                               fire,
   input  kpsd_pkg::req_item_type             item,
   output kpsd_pkg::rsp_item_type             result
);
   import kpsd_pkg::*;

   logic [IdleWidth-1:0]   lock_delay_ff;
   logic [KeyWidth-1:0]    scan_bits_ff, scan_bits_in;
   logic [ColIdxWidth-1:0] column_index_ff, column_index_in;
   logic [KeyWidth-1:0]    candidate_key_ff, candidate_key_in;
   logic [CountWidth-1:0]  press_count_ff, press_count_in;
   logic [CountWidth-1:0]  release_count_ff, release_count_in;
   logic [KeyWidth-1:0]    key_state_ff, key_state_in;
   logic [IdleWidth-1:0]   idle_scans_ff, idle_scans_in;
   logic                   locked_ff, locked_in;

   logic [KeyWidth-1:0]    scan_word;
   logic [KeyWidth-1:0]    pressed;
   logic                   ready;
   logic [CountWidth-1:0]  press_dec;
   logic [IdleWidth-1:0]   idle_mid;

   assign scan_word = {scan_bits_ff[KeyWidth-RowWidth-1:0], ~item.row_sample};
   assign pressed   = key_state_ff & item.key_mask;
   assign ready     = locked_ff || (pressed != '0);
   assign press_dec = press_count_ff - CountWidth'(1);

   always_comb begin
      scan_bits_in     = scan_bits_ff;
      column_index_in  = column_index_ff;
      candidate_key_in = candidate_key_ff;
      press_count_in   = press_count_ff;
      release_count_in = release_count_ff;
      key_state_in     = key_state_ff;
      idle_scans_in    = idle_scans_ff;
      locked_in        = locked_ff;
      idle_mid         = idle_scans_ff;

      if (item.mode == MODE_READ) begin
         if (ready) begin
            key_state_in = '0;
         end
      end else if (column_index_ff != LastCol) begin
         column_index_in = column_index_ff + ColIdxWidth'(1);
         scan_bits_in    = scan_word;
      end else begin
         column_index_in = '0;
         scan_bits_in    = '0;
         if (scan_word == '0) begin
            press_count_in   = PressRestart;
            release_count_in = '0;
         end else begin
            if (locked_ff) begin
               idle_mid = lock_delay_ff;
            end
            if (release_count_ff != '0) begin
               release_count_in = release_count_ff - CountWidth'(1);
            end else begin
               press_count_in = press_dec;
               priority if (press_dec == PressCapture) begin
                  candidate_key_in = scan_word;
               end else if (scan_word != candidate_key_ff) begin
                  press_count_in   = PressRestart;
                  release_count_in = '0;
               end else if (press_dec == '0) begin
                  key_state_in     = scan_word;
                  idle_mid         = '0;
                  release_count_in = ReleaseLoad;
               end else begin
                  // still counting down on a steady scan
                  press_count_in = press_dec;
               end
            end
         end
         if (idle_mid >= lock_delay_ff) begin
            locked_in     = 1'b1;
            idle_scans_in = idle_mid;
         end else begin
            locked_in     = 1'b0;
            idle_scans_in = idle_mid + IdleWidth'(1);
         end
      end
   end

   always_comb begin
      result.column_drive = col_drive(column_index_in);
      result.lock_flag    = locked_in;
      if (item.mode == MODE_READ) begin
         result.key_bits   = pressed;
         result.read_ready = ready;
      end else begin
         result.key_bits   = key_state_in;
         result.read_ready = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_delay_ff    <= LockDelayReset;
         scan_bits_ff     <= '0;
         column_index_ff  <= '0;
         candidate_key_ff <= '0;
         press_count_ff   <= PressReset;
         release_count_ff <= '0;
         key_state_ff     <= '0;
         idle_scans_ff    <= '0;
         locked_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            lock_delay_ff <= csr_wdata;
         end
         if (fire) begin
            scan_bits_ff     <= scan_bits_in;
            column_index_ff  <= column_index_in;
            candidate_key_ff <= candidate_key_in;
            press_count_ff   <= press_count_in;
            release_count_ff <= release_count_in;
            key_state_ff     <= key_state_in;
            idle_scans_ff    <= idle_scans_in;
            locked_ff        <= locked_in;
         end
      end
   end

   `KPSD_ASSERT_NEXT(a_read_holds_column, clock, reset, fire && item.mode == MODE_READ, $stable(column_index_ff), "read transaction moved the column")
   `KPSD_ASSERT_NEXT(a_scan_end_clears, clock, reset, fire && item.mode == MODE_SCAN && column_index_ff == LastCol, scan_bits_ff == '0 && column_index_ff == '0, "scan word not cleared at end of scan")
   `KPSD_ASSERT_NEXT(a_ready_clears_keys, clock, reset, fire && item.mode == MODE_READ && ready, key_state_ff == '0, "ready read did not clear key state")
   `KPSD_ASSERT_NEXT(a_lock_tracks_idle, clock, reset, fire && item.mode == MODE_SCAN && column_index_ff == LastCol && !csr_we, !locked_ff || idle_scans_ff >= lock_delay_ff, "lock set below idle threshold")

endmodule

@@ sv/kpsd_out_reg.sv @@
module kpsd_out_reg (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  kpsd_pkg::rsp_item_type                result,
   output logic                                  out_ready,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [kpsd_pkg::RspDataWidth-1:0]     rsp_tdata
);
   import kpsd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   assign out_ready = !valid_ff || rsp_tready;
   assign valid_in  = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'b0, data_ff.read_ready, data_ff.lock_flag,
                        data_ff.key_bits, data_ff.column_drive};

endmodule
